[src/tll_pkg.sv]
// shared types, constants and the power table for the two-channel lux pipeline
// no dependencies; used by tll_div and two_channel_light_lux
`timescale 1ns / 1ps
`default_nettype none

package tll_pkg;

	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned RATIO_W     = COUNT_W + 1;
	localparam int unsigned ROM_ENTRIES = 256;
	localparam int unsigned IDX_W       = $clog2(ROM_ENTRIES);
	localparam int unsigned IDX_SCALE   = 2 * (ROM_ENTRIES - 1);
	localparam int unsigned IDX_SCALE_W = $clog2(IDX_SCALE + 1);
	localparam int unsigned COEF_A_W    = 19;
	localparam int unsigned COEF_B_W    = 20;
	localparam int unsigned HI_W        = COEF_A_W + COUNT_W;
	localparam int unsigned LO_W        = COEF_B_W + RATIO_W;
	localparam int unsigned LUX_W       = 19;
	localparam int unsigned LUX_SHIFT   = 32;
	localparam int unsigned T_SPLIT     = 18;
	localparam int unsigned CMP_W       = 24;

	localparam logic [CMP_W-1:0] KNEE_SCALE = CMP_W'(100);
	localparam logic [CMP_W-1:0] KNEE_0     = CMP_W'(50);
	localparam logic [CMP_W-1:0] KNEE_1     = CMP_W'(61);
	localparam logic [CMP_W-1:0] KNEE_2     = CMP_W'(80);
	localparam logic [CMP_W-1:0] KNEE_3     = CMP_W'(130);

	typedef enum logic [1:0] {
		SEG_LOW     = 2'd0,
		SEG_MIDLOW  = 2'd1,
		SEG_MIDHIGH = 2'd2,
		SEG_HIGH    = 2'd3
	} seg_t;

	localparam logic [COEF_A_W-1:0] SEG_A [4] = '{
		COEF_A_W'(510027), COEF_A_W'(375810), COEF_A_W'(214748), COEF_A_W'(24495)
	};
	localparam logic [COEF_B_W-1:0] SEG_B [4] = '{
		COEF_B_W'(1040187), COEF_B_W'(520094), COEF_B_W'(256691), COEF_B_W'(18790)
	};

	typedef struct packed {
		logic [COUNT_W-1:0] ch0;
		seg_t               seg;
		logic               oor;
	} side_t;

	typedef struct packed {
		logic [RATIO_W-1:0] quo;
		logic [COUNT_W-1:0] rem;
	} div_state_t;

	// restoring division steps, the first step shifts in din, the rest shift in zero
	function automatic div_state_t div_run(input div_state_t s, input logic [COUNT_W-1:0] den,
			input logic din, input int unsigned steps);
		div_state_t        r;
		logic [COUNT_W:0]  sh;
		r = s;
		for (int unsigned k = 0; k < steps; k++) begin
			sh = {r.rem, (k == 0) ? din : 1'b0};
			if (sh >= {1'b0, den}) begin
				sh    = sh - {1'b0, den};
				r.quo = {r.quo[RATIO_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[RATIO_W-2:0], 1'b0};
			end
			r.rem = sh[COUNT_W-1:0];
		end
		return r;
	endfunction

	typedef logic [ROM_ENTRIES-1:0][COUNT_W-1:0] rom_t;

	function automatic logic [63:0] fifth_power(input logic [63:0] z);
		logic [63:0] p;
		p = z;
		for (int k = 0; k < 4; k++) begin
			p = (p * z) >> 16;
		end
		return p;
	endfunction

	// ratio^1.4 in q16 over ratio 0 to 0.5, evaluated at elaboration
	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		logic [63:0] tgt;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		for (int i = 0; i < ROM_ENTRIES; i++) begin
			x   = (64'(i) << 15) / 64'(ROM_ENTRIES - 1);
			tgt = (x * x) >> 16;
			lo  = 64'd0;
			hi  = 64'd65536;
			for (int k = 0; k < 18; k++) begin
				if (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					if (fifth_power(mid) <= tgt) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
			end
			r[i] = COUNT_W'((x * lo) >> 16);
		end
		return r;
	endfunction

	localparam rom_t POW_ROM = build_rom();

endpackage

`default_nettype wire

[src/tll_div.sv]
// pipelined restoring divider: (ch1 << 16) / ch0 as a 17-bit quotient over four stages
// depends on tll_pkg
`timescale 1ns / 1ps
`default_nettype none

module tll_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tll_pkg::COUNT_W-1:0] in_ch1,
	input  wire tll_pkg::side_t              in_side,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tll_pkg::RATIO_W-1:0]      out_quot,
	output tll_pkg::side_t                   out_side
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	tll_pkg::div_state_t st_s1, st_s2, st_s3, st_s4;
	tll_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	tll_pkg::div_state_t init_c, nxt1_c, nxt2_c, nxt3_c, nxt4_c;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// upper dividend bits are below the divisor whenever the item is in range
	assign init_c = '{quo: '0, rem: {1'b0, in_ch1[tll_pkg::COUNT_W-1:1]}};
	assign nxt1_c = tll_pkg::div_run(init_c, in_side.ch0, in_ch1[0], 5);
	assign nxt2_c = tll_pkg::div_run(st_s1, side_s1.ch0, 1'b0, 4);
	assign nxt3_c = tll_pkg::div_run(st_s2, side_s2.ch0, 1'b0, 4);
	assign nxt4_c = tll_pkg::div_run(st_s3, side_s3.ch0, 1'b0, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			st_s1   <= nxt1_c;
			side_s1 <= in_side;
		end
		if (en_s2 && v_s1) begin
			st_s2   <= nxt2_c;
			side_s2 <= side_s1;
		end
		if (en_s3 && v_s2) begin
			st_s3   <= nxt3_c;
			side_s3 <= side_s2;
		end
		if (en_s4 && v_s3) begin
			st_s4   <= nxt4_c;
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_quot  = st_s4.quo;
	assign out_side  = side_s4;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !side_s4.oor) |-> (st_s4.rem < side_s4.ch0))
		else $error("divider remainder not below divisor");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted transfer did not enter first divider stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s3) |=> (v_s3 && $stable(st_s3)))
		else $error("stalled divider stage changed");

endmodule

`default_nettype wire

[src/two_channel_light_lux.sv]
// two-channel light sensor lux pipeline: segment select, ratio divide, table and multiply
// depends on tll_pkg and tll_div
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// One input transfer on the s_ group carries a pair of counts: broadband channel 0
// in s_tdata[15:0] and infrared channel 1 in s_tdata[31:16]. Each input transfer gives
// exactly one result transfer on the m_ group, in order: lux times 256 in
// m_tdata[18:0] and the out-of-range flag in m_tuser (zero count or ratio above 1.30,
// lux then zero).
// From the input transfer to m_tvalid an item passes one compare stage, four divider
// stages of four to five quotient bits each, table and coefficient stages, a split
// 16 x 35 multiply and the output register.
// Throughput is one pair per cycle while m_tready stays high; each stage carries its own valid bit and takes
// a new item whenever it is empty or its contents move on.
// When the receiver holds m_tready low, the result stays on m_tdata/m_tuser and the
// pipeline keeps filling its empty stages; s_tready drops only once every stage is full.
// Reset (arst_n low) empties all stages at once; no table or memory needs clearing.
module two_channel_light_lux (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // broadband_count, infrared_count
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // lux_scaled, zero pad
	output logic             m_tuser    // out_of_range
);

	localparam int unsigned CW = tll_pkg::COUNT_W;
	localparam int unsigned RW = tll_pkg::RATIO_W;

	// stage 1: segment compares
	logic                 v_s1, en_s1;
	logic [CW-1:0]        ch1_s1;
	tll_pkg::side_t       side_s1;
	logic [CW-1:0]        ch0_c, ch1_c;
	logic [tll_pkg::CMP_W-1:0] ch1x_c, ch0x0_c, ch0x1_c, ch0x2_c, ch0x3_c;
	tll_pkg::side_t       side_c;

	// divider
	logic                 dv_valid, dv_ready;
	logic                 dv_ready_in;
	logic [RW-1:0]        dv_quot;
	tll_pkg::side_t       dv_side;

	// stage 6: table index and upper term
	logic                 v_s6, en_s6;
	logic [RW-1:0]        rq_s6;
	logic [tll_pkg::IDX_W-1:0] idx_s6;
	logic [tll_pkg::HI_W-1:0]  hi_s6;
	tll_pkg::side_t       side_s6;
	logic [RW+tll_pkg::IDX_SCALE_W-1:0] idx_prod_c;
	logic [RW+tll_pkg::IDX_SCALE_W-17:0] idx_full_c;

	// stage 7: lower term
	logic                 v_s7, en_s7;
	logic [tll_pkg::HI_W-1:0]  hi_s7;
	logic [tll_pkg::LO_W-1:0]  lo_s7;
	logic [CW-1:0]        ch0_s7;
	logic                 oor_s7;
	logic [RW-1:0]        f_c;

	// stage 8: segment value
	logic                 v_s8, en_s8;
	logic [tll_pkg::HI_W-1:0]  t_s8;
	logic [CW-1:0]        ch0_s8;
	logic                 oor_s8;

	// stage 9: partial products
	logic                 v_s9, en_s9;
	logic [CW+tll_pkg::T_SPLIT-1:0]                         plo_s9;
	logic [CW+tll_pkg::HI_W-tll_pkg::T_SPLIT-1:0]           phi_s9;
	logic                 oor_s9;

	// output register
	logic                 out_valid_q, en_out;
	logic [tll_pkg::LUX_W-1:0] lux_q;
	logic                 oor_q;
	logic [CW+tll_pkg::HI_W-1:0] sum_c;

	assign en_out   = !out_valid_q || m_tready;
	assign en_s9    = !v_s9 || en_out;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign dv_ready = en_s6;
	assign en_s1    = !v_s1 || dv_ready_in;

	assign s_tready = en_s1;

	assign ch0_c   = s_tdata[CW-1:0];
	assign ch1_c   = s_tdata[2*CW-1:CW];
	assign ch1x_c  = tll_pkg::CMP_W'(ch1_c) * tll_pkg::KNEE_SCALE;
	assign ch0x0_c = tll_pkg::CMP_W'(ch0_c) * tll_pkg::KNEE_0;
	assign ch0x1_c = tll_pkg::CMP_W'(ch0_c) * tll_pkg::KNEE_1;
	assign ch0x2_c = tll_pkg::CMP_W'(ch0_c) * tll_pkg::KNEE_2;
	assign ch0x3_c = tll_pkg::CMP_W'(ch0_c) * tll_pkg::KNEE_3;

	always_comb begin
		side_c.ch0 = ch0_c;
		side_c.oor = (ch0_c == '0) || (ch1x_c > ch0x3_c);
		if (ch1x_c <= ch0x0_c) begin
			side_c.seg = tll_pkg::SEG_LOW;
		end else if (ch1x_c <= ch0x1_c) begin
			side_c.seg = tll_pkg::SEG_MIDLOW;
		end else if (ch1x_c <= ch0x2_c) begin
			side_c.seg = tll_pkg::SEG_MIDHIGH;
		end else begin
			side_c.seg = tll_pkg::SEG_HIGH;
		end
	end

	tll_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (dv_ready_in),
		.in_ch1    (ch1_s1),
		.in_side   (side_s1),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	assign idx_prod_c = (RW + tll_pkg::IDX_SCALE_W)'(dv_quot)
		* (RW + tll_pkg::IDX_SCALE_W)'(tll_pkg::IDX_SCALE);
	assign idx_full_c = idx_prod_c[RW+tll_pkg::IDX_SCALE_W-1:16];

	always_comb begin
		if (side_s6.seg == tll_pkg::SEG_LOW) begin
			f_c = RW'(tll_pkg::POW_ROM[idx_s6]);
		end else begin
			f_c = rq_s6;
		end
	end

	assign sum_c = {phi_s9, {tll_pkg::T_SPLIT{1'b0}}} + (CW + tll_pkg::HI_W)'(plo_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s6) v_s6 <= dv_valid;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
			if (en_out) out_valid_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			ch1_s1  <= ch1_c;
			side_s1 <= side_c;
		end
		if (en_s6 && dv_valid) begin
			rq_s6   <= dv_quot;
			side_s6 <= dv_side;
			hi_s6   <= {tll_pkg::SEG_A[dv_side.seg], {CW{1'b0}}};
			if (idx_full_c > ($bits(idx_full_c))'(tll_pkg::ROM_ENTRIES - 1)) begin
				idx_s6 <= tll_pkg::IDX_W'(tll_pkg::ROM_ENTRIES - 1);
			end else begin
				idx_s6 <= idx_full_c[tll_pkg::IDX_W-1:0];
			end
		end
		if (en_s7 && v_s6) begin
			hi_s7  <= hi_s6;
			lo_s7  <= tll_pkg::LO_W'(tll_pkg::SEG_B[side_s6.seg]) * tll_pkg::LO_W'(f_c);
			ch0_s7 <= side_s6.ch0;
			oor_s7 <= side_s6.oor;
		end
		if (en_s8 && v_s7) begin
			if (tll_pkg::LO_W'(hi_s7) > lo_s7) begin
				t_s8 <= hi_s7 - lo_s7[tll_pkg::HI_W-1:0];
			end else begin
				t_s8 <= '0;
			end
			ch0_s8 <= ch0_s7;
			oor_s8 <= oor_s7;
		end
		if (en_s9 && v_s8) begin
			plo_s9 <= ($bits(plo_s9))'(ch0_s8) * ($bits(plo_s9))'(t_s8[tll_pkg::T_SPLIT-1:0]);
			phi_s9 <= ($bits(phi_s9))'(ch0_s8)
				* ($bits(phi_s9))'(t_s8[tll_pkg::HI_W-1:tll_pkg::T_SPLIT]);
			oor_s9 <= oor_s8;
		end
		if (en_out && v_s9) begin
			lux_q <= oor_s9 ? '0 : sum_c[tll_pkg::LUX_SHIFT+tll_pkg::LUX_W-1:tll_pkg::LUX_SHIFT];
			oor_q <= oor_s9;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24 - tll_pkg::LUX_W){1'b0}}, lux_q};
	assign m_tuser  = oor_q;

	a_oor_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[18:0] == '0))
		else $error("out-of-range result with nonzero lux");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted transfer did not enter compare stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && !en_s8) |=> (v_s8 && $stable(t_s8)))
		else $error("stalled segment stage changed");

endmodule

`default_nettype wire
